>>> rtl/rdmc_pkg.sv
package rdmc_pkg;

	localparam int GRID_MAX_DEF = 64;
	localparam int EPOCH_W      = 4;
	localparam int SIDE_W       = 7;
	localparam int POS_W        = 6;
	localparam int RAND_W       = 16;
	localparam int CFG_W        = 7;
	localparam int CFG_IDX_W    = 2;

	localparam logic [CFG_IDX_W-1:0] REG_GRID_SIDE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_START_ROW = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_START_COL = 2'd2;

	localparam logic KIND_START = 1'b0;
	localparam logic KIND_STEP  = 1'b1;

	typedef enum logic [1:0] {
		DIR_UP    = 2'd0,
		DIR_RIGHT = 2'd1,
		DIR_DOWN  = 2'd2,
		DIR_LEFT  = 2'd3
	} dir_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RD,
		ST_EVAL,
		ST_POP
	} ctrl_state_t;

	typedef struct packed {
		logic              kind;
		logic [RAND_W-1:0] rand_value;
	} cmd_t;

	typedef struct packed {
		logic             edge_valid;
		logic [POS_W-1:0] from_row;
		logic [POS_W-1:0] from_col;
		logic [POS_W-1:0] to_row;
		logic [POS_W-1:0] to_col;
		logic [1:0]       direction;
		logic             done_res;
	} res_t;

	// control from the walk sequencer to the visited map
	typedef struct packed {
		logic new_map;
		logic mark;
	} vis_ctl_t;

endpackage

>>> rtl/rdmc_visited.sv
module rdmc_visited #(
	parameter int AW = 12
) (
	input  logic               clk,
	input  logic               arst_n,
	input  rdmc_pkg::vis_ctl_t ctl,
	input  logic [AW-1:0]      mark_addr,
	input  logic [AW-1:0]      raddr_a,
	input  logic [AW-1:0]      raddr_b,
	output logic               vis_a,
	output logic               vis_b,
	output logic               clearing
);
	import rdmc_pkg::*;

	localparam int DEPTH = 2 ** AW;

	// each entry holds the epoch of the map in which it was visited;
	// epoch zero never matches, so a swept entry reads as open
	logic [EPOCH_W-1:0] tag_mem [DEPTH];
	logic [EPOCH_W-1:0] epoch_q;
	logic               clear_q;
	logic [AW-1:0]      clr_cnt_q;
	logic [EPOCH_W-1:0] tag_a_q;
	logic [EPOCH_W-1:0] tag_b_q;
	logic               wr_en;
	logic [AW-1:0]      wr_addr;
	logic [EPOCH_W-1:0] wr_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			epoch_q   <= '1;
			clear_q   <= 1'b0;
			clr_cnt_q <= '0;
		end else begin
			if (ctl.new_map) begin
				if (epoch_q == '1) begin
					// epochs used up: sweep the whole map back to zero
					epoch_q   <= EPOCH_W'(1);
					clear_q   <= 1'b1;
					clr_cnt_q <= '0;
				end else begin
					epoch_q <= epoch_q + EPOCH_W'(1);
				end
			end else if (clear_q) begin
				clr_cnt_q <= clr_cnt_q + AW'(1);
				if (clr_cnt_q == '1) clear_q <= 1'b0;
			end
		end
	end

	always_comb begin
		wr_en   = clear_q | ctl.mark;
		wr_addr = clear_q ? clr_cnt_q : mark_addr;
		wr_data = clear_q ? '0 : epoch_q;
	end

	always_ff @(posedge clk) begin
		if (wr_en) tag_mem[wr_addr] <= wr_data;
		tag_a_q <= tag_mem[raddr_a];
		tag_b_q <= tag_mem[raddr_b];
	end

	assign vis_a    = (tag_a_q == epoch_q);
	assign vis_b    = (tag_b_q == epoch_q);
	assign clearing = clear_q;

endmodule

>>> rtl/rdmc_stack.sv
module rdmc_stack #(
	parameter int SA = 12,
	parameter int DW = 12
) (
	input  logic          clk,
	input  logic          we,
	input  logic [SA-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [SA-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [2 ** SA];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

>>> rtl/rdmc_ctrl.sv
module rdmc_ctrl #(
	parameter int GRID_MAX = rdmc_pkg::GRID_MAX_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  rdmc_pkg::cmd_t                    cmd,
	input  logic [rdmc_pkg::SIDE_W-1:0]       side,
	input  logic [2*$clog2(GRID_MAX)-1:0]     start_cell,
	output logic                              busy,
	output logic                              res_valid,
	output rdmc_pkg::res_t                    res
);
	import rdmc_pkg::*;

	localparam int CW    = $clog2(GRID_MAX);
	localparam int AW    = 2 * CW;
	localparam int DEPTH = GRID_MAX * GRID_MAX;
	localparam int SA    = $clog2(DEPTH);
	localparam int LW    = $clog2(DEPTH + 1);
	localparam int BW    = CW + 1;

	ctrl_state_t state_q, state_nx;

	logic [AW-1:0]     top_q;
	logic [LW-1:0]     level_q;
	logic              vis_up_q;
	logic              vis_rt_q;
	logic [1:0]        rnd_lo_q;
	logic [1:0]        rnd_m3_q;
	logic              res_valid_q;
	res_t              res_q;

	logic              accept;
	logic              clearing;
	vis_ctl_t          vctl;
	logic [AW-1:0]     raddr_a;
	logic [AW-1:0]     raddr_b;
	logic              vis_a;
	logic              vis_b;
	logic              stk_we;
	logic [SA-1:0]     stk_waddr;
	logic [AW-1:0]     stk_wdata;
	logic [SA-1:0]     stk_raddr;
	logic [AW-1:0]     stk_rdata;

	logic [CW-1:0]     r;
	logic [CW-1:0]     c;
	logic [BW-1:0]     r_w;
	logic [BW-1:0]     c_w;
	logic [BW-1:0]     side_w;
	logic [3:0]        in_grid;
	logic [3:0]        open;
	logic [2:0]        n_open;
	logic [1:0]        pick;
	dir_t              dir;
	logic [CW-1:0]     to_r;
	logic [CW-1:0]     to_c;
	logic [AW-1:0]     addr_up;
	logic [AW-1:0]     addr_rt;
	logic [AW-1:0]     addr_dn;
	logic [AW-1:0]     addr_lf;
	logic              can_push;
	logic [LW-1:0]     level_dec;
	logic              res_valid_nx;
	res_t              res_nx;

	function automatic logic [1:0] mod3(input logic [RAND_W-1:0] v);
		logic [4:0] s;
		logic [2:0] t;
		logic [2:0] u;
		s = '0;
		// four is one modulo three, so the base-4 digits simply add up
		for (int i = 0; i < RAND_W / 2; i++) s = s + 5'(v[2*i +: 2]);
		t = 3'(s[1:0]) + 3'(s[3:2]) + 3'(s[4]);
		u = 3'(t[1:0]) + 3'(t[2]);
		if (u >= 3'd3) u = u - 3'd3;
		return u[1:0];
	endfunction

	assign accept = start & ~busy;

	// neighbour geometry around the top cell
	always_comb begin
		r      = top_q[AW-1:CW];
		c      = top_q[CW-1:0];
		r_w    = BW'(r);
		c_w    = BW'(c);
		side_w = (BW > SIDE_W) ? BW'(side) : BW'(side);
		in_grid[DIR_UP]    = (r != '0) && (r_w - BW'(1) < side_w) && (c_w < side_w);
		in_grid[DIR_RIGHT] = (r_w < side_w) && (c_w + BW'(1) < side_w);
		in_grid[DIR_DOWN]  = (r_w + BW'(1) < side_w) && (c_w < side_w);
		in_grid[DIR_LEFT]  = (c != '0) && (r_w < side_w) && (c_w - BW'(1) < side_w);
		addr_up = {r - CW'(1), c};
		addr_rt = {r, c + CW'(1)};
		addr_dn = {r + CW'(1), c};
		addr_lf = {r, c - CW'(1)};
	end

	// candidate choice, valid in ST_EVAL
	always_comb begin
		logic [1:0] k;
		logic [2:0] seen;
		logic       found;
		open[DIR_UP]    = in_grid[DIR_UP] & ~vis_up_q;
		open[DIR_RIGHT] = in_grid[DIR_RIGHT] & ~vis_rt_q;
		open[DIR_DOWN]  = in_grid[DIR_DOWN] & ~vis_a;
		open[DIR_LEFT]  = in_grid[DIR_LEFT] & ~vis_b;
		n_open = 3'(open[0]) + 3'(open[1]) + 3'(open[2]) + 3'(open[3]);
		case (n_open)
			3'd2:    k = {1'b0, rnd_lo_q[0]};
			3'd3:    k = rnd_m3_q;
			3'd4:    k = rnd_lo_q;
			default: k = 2'd0;
		endcase
		seen  = '0;
		found = 1'b0;
		pick  = 2'd0;
		for (int i = 0; i < 4; i++) begin
			if (open[i] && !found && seen == 3'(k)) begin
				pick  = 2'(i);
				found = 1'b1;
			end
			if (open[i]) seen = seen + 3'd1;
		end
		dir  = dir_t'(pick);
		to_r = r;
		to_c = c;
		case (dir)
			DIR_UP:    to_r = r - CW'(1);
			DIR_RIGHT: to_c = c + CW'(1);
			DIR_DOWN:  to_r = r + CW'(1);
			DIR_LEFT:  to_c = c - CW'(1);
			default:   to_r = r;
		endcase
		can_push  = (32'(level_q) < DEPTH);
		level_dec = level_q - LW'(1);
	end

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && cmd.kind == KIND_STEP && level_q != '0) state_nx = ST_RD;
			end
			ST_RD:   state_nx = ST_EVAL;
			ST_EVAL: begin
				if (n_open == 3'd0 && level_dec != '0) state_nx = ST_POP;
				else state_nx = ST_IDLE;
			end
			ST_POP:  state_nx = ST_IDLE;
			default: state_nx = ST_IDLE;
		endcase
	end

	// result transaction contents
	always_comb begin
		res_nx       = '0;
		res_valid_nx = 1'b0;
		case (state_q)
			ST_IDLE: begin
				res_valid_nx    = accept && (cmd.kind == KIND_START || level_q == '0);
				res_nx.done_res = accept && cmd.kind == KIND_STEP && level_q == '0;
			end
			ST_EVAL: begin
				res_valid_nx = 1'b1;
				if (n_open == 3'd0) begin
					res_nx.done_res = (level_dec == '0);
				end else begin
					res_nx.edge_valid = 1'b1;
					res_nx.from_row   = POS_W'(r);
					res_nx.from_col   = POS_W'(c);
					res_nx.to_row     = POS_W'(to_r);
					res_nx.to_col     = POS_W'(to_c);
					res_nx.direction  = dir;
				end
			end
			default: res_valid_nx = 1'b0;
		endcase
	end

	// memory port control
	always_comb begin
		vctl.new_map = accept && cmd.kind == KIND_START;
		vctl.mark    = (state_q == ST_EVAL);
		raddr_a      = (state_q == ST_IDLE) ? addr_up : addr_dn;
		raddr_b      = (state_q == ST_IDLE) ? addr_rt : addr_lf;
		stk_we       = 1'b0;
		stk_waddr    = '0;
		stk_wdata    = start_cell;
		stk_raddr    = SA'(level_q - LW'(2));
		case (state_q)
			ST_IDLE: stk_we = accept && cmd.kind == KIND_START;
			ST_EVAL: begin
				stk_we    = (n_open != 3'd0) && can_push;
				stk_waddr = level_q[SA-1:0];
				stk_wdata = {to_r, to_c};
			end
			default: stk_we = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			level_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q     <= state_nx;
			res_valid_q <= res_valid_nx;
			case (state_q)
				ST_IDLE: begin
					if (accept && cmd.kind == KIND_START) level_q <= LW'(1);
				end
				ST_EVAL: begin
					if (n_open == 3'd0) level_q <= level_dec;
					else if (can_push) level_q <= level_q + LW'(1);
				end
				default: level_q <= level_q;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				rnd_lo_q <= cmd.rand_value[1:0];
				rnd_m3_q <= mod3(cmd.rand_value);
				res_q    <= res_nx;
				if (accept && cmd.kind == KIND_START) top_q <= start_cell;
			end
			ST_RD: begin
				vis_up_q <= vis_a;
				vis_rt_q <= vis_b;
			end
			ST_EVAL: begin
				res_q <= res_nx;
				if (n_open != 3'd0 && can_push) top_q <= {to_r, to_c};
			end
			ST_POP:  top_q <= stk_rdata;
			default: top_q <= top_q;
		endcase
	end

	rdmc_visited #(.AW(AW)) u_visited (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (vctl),
		.mark_addr(top_q),
		.raddr_a  (raddr_a),
		.raddr_b  (raddr_b),
		.vis_a    (vis_a),
		.vis_b    (vis_b),
		.clearing (clearing)
	);

	rdmc_stack #(.SA(SA), .DW(AW)) u_stack (
		.clk  (clk),
		.we   (stk_we),
		.waddr(stk_waddr),
		.wdata(stk_wdata),
		.raddr(stk_raddr),
		.rdata(stk_rdata)
	);

	assign busy      = (state_q != ST_IDLE) || clearing;
	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

>>> rtl/random_dfs_maze_carver.sv
// channel    signals                         transaction at
// ---------  ------------------------------  -------------------------------
// command    start, busy, cmd                rising edge with start & !busy
// result     res_valid, res                  every edge with res_valid high
// config     cfg_we, cfg_idx, cfg_data       every edge with cfg_we high
//
// a start, or a step on an empty stack, is answered from idle; any other step passes
// through accept, read up/right, read down/left and evaluate, and a pop state if a pop
// leaves cells on the stack and the new top cell is read back from the stack memory.
// the result is out for one cycle: after the accept cycle, or after the evaluate cycle.
// the visited map is a tag memory: the first start after reset and every 15th start
// after it sweep all 2**(2*clog2(GRID_MAX)) entries (4096 at default) with busy held.
// the receiver cannot stall; configuration is taken at any time.
module random_dfs_maze_carver #(
	parameter int GRID_MAX = rdmc_pkg::GRID_MAX_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  rdmc_pkg::cmd_t                   cmd,
	output logic                             busy,
	output logic                             res_valid,
	output rdmc_pkg::res_t                   res,
	input  logic                             cfg_we,
	input  logic [rdmc_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  logic [rdmc_pkg::CFG_W-1:0]       cfg_data
);
	import rdmc_pkg::*;

	localparam int CW = $clog2(GRID_MAX);

	logic [SIDE_W-1:0] grid_side_q;
	logic [POS_W-1:0]  start_row_q;
	logic [POS_W-1:0]  start_col_q;
	logic [SIDE_W-1:0] side;
	logic [SIDE_W-1:0] side_m1;
	logic [SIDE_W-1:0] row_cl;
	logic [SIDE_W-1:0] col_cl;
	logic [2*CW-1:0]   start_cell;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_side_q <= SIDE_W'(4);
			start_row_q <= '0;
			start_col_q <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_GRID_SIDE: grid_side_q <= cfg_data[SIDE_W-1:0];
				REG_START_ROW: start_row_q <= cfg_data[POS_W-1:0];
				REG_START_COL: start_col_q <= cfg_data[POS_W-1:0];
				default:       grid_side_q <= grid_side_q;
			endcase
		end
	end

	// saturate the side to the supported range, clamp the start cell into it
	always_comb begin
		if (grid_side_q < SIDE_W'(2)) side = SIDE_W'(2);
		else if (32'(grid_side_q) > GRID_MAX) side = SIDE_W'(GRID_MAX);
		else side = grid_side_q;
		side_m1 = side - SIDE_W'(1);
		row_cl  = (SIDE_W'(start_row_q) > side_m1) ? side_m1 : SIDE_W'(start_row_q);
		col_cl  = (SIDE_W'(start_col_q) > side_m1) ? side_m1 : SIDE_W'(start_col_q);
		start_cell = {CW'(row_cl), CW'(col_cl)};
	end

	rdmc_ctrl #(.GRID_MAX(GRID_MAX)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.cmd       (cmd),
		.side      (side),
		.start_cell(start_cell),
		.busy      (busy),
		.res_valid (res_valid),
		.res       (res)
	);

endmodule

>>> tb/random_dfs_maze_carver_tb.sv
`timescale 1ns / 1ps

module random_dfs_maze_carver_tb;
	import rdmc_pkg::*;

	localparam int GRID_MAX    = GRID_MAX_DEF;
	localparam int CELLS       = GRID_MAX * GRID_MAX;
	localparam int STALL_LIMIT = 12000;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 start = 1'b0;
	cmd_t                 cmd = '0;
	logic                 busy;
	logic                 res_valid;
	res_t                 res;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_idx = '0;
	logic [CFG_W-1:0]     cfg_data = '0;

	random_dfs_maze_carver DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.cmd(cmd),
		.busy(busy),
		.res_valid(res_valid),
		.res(res),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// maze walk mirror
	bit              seen_cells [CELLS];
	logic [11:0]     path_stack [CELLS];
	int unsigned     path_depth = 0;
	logic [SIDE_W-1:0] side_cfg = 7'd4;
	logic [POS_W-1:0]  row_cfg = '0;
	logic [POS_W-1:0]  col_cfg = '0;

	cmd_t        pending_cmds [$];
	res_t        carve_expect_q [$];
	int unsigned fail_count = 0;
	int unsigned items_queued = 0;
	int unsigned burst_left = 1;
	int unsigned gap_left = 0;
	int unsigned stall_cycles = 0;
	res_t        want;

	function automatic bit cell_free(input int unsigned row, col, side);
		if (row >= side || col >= side)
			return 1'b0;
		return !seen_cells[row * GRID_MAX + col];
	endfunction

	function automatic res_t carve_step(input cmd_t c);
		res_t        r;
		int unsigned side, row, col, n;
		dir_t        opts [4];
		dir_t        d;
		r = '0;
		side = side_cfg;
		if (side < 2)
			side = 2;
		if (side > GRID_MAX)
			side = GRID_MAX;
		if (c.kind == KIND_START) begin
			row = (row_cfg > side - 1) ? side - 1 : row_cfg;
			col = (col_cfg > side - 1) ? side - 1 : col_cfg;
			foreach (seen_cells[i])
				seen_cells[i] = 1'b0;
			path_stack[0] = {POS_W'(row), POS_W'(col)};
			path_depth = 1;
			return r;
		end
		if (path_depth != 0) begin
			row = path_stack[path_depth - 1][2*POS_W-1:POS_W];
			col = path_stack[path_depth - 1][POS_W-1:0];
			seen_cells[row * GRID_MAX + col] = 1'b1;
			n = 0;
			if (row > 0 && cell_free(row - 1, col, side)) begin
				opts[n] = DIR_UP;
				n++;
			end
			if (cell_free(row, col + 1, side)) begin
				opts[n] = DIR_RIGHT;
				n++;
			end
			if (cell_free(row + 1, col, side)) begin
				opts[n] = DIR_DOWN;
				n++;
			end
			if (col > 0 && cell_free(row, col - 1, side)) begin
				opts[n] = DIR_LEFT;
				n++;
			end
			if (n == 0) begin
				// dead end, backtrack
				path_depth--;
			end else begin
				d = opts[c.rand_value % n];
				r.edge_valid = 1'b1;
				r.from_row = POS_W'(row);
				r.from_col = POS_W'(col);
				r.to_row = POS_W'(row);
				r.to_col = POS_W'(col);
				r.direction = d;
				case (d)
					DIR_UP: r.to_row = POS_W'(row - 1);
					DIR_RIGHT: r.to_col = POS_W'(col + 1);
					DIR_DOWN: r.to_row = POS_W'(row + 1);
					default: r.to_col = POS_W'(col - 1);
				endcase
				if (path_depth < CELLS) begin
					path_stack[path_depth] = {r.to_row, r.to_col};
					path_depth++;
				end
			end
		end
		r.done_res = (path_depth == 0);
		return r;
	endfunction

	task automatic check_field(input string name, input logic [6:0] exp_v, got_v);
		if (exp_v !== got_v) begin
			fail_count++;
			$error("%s: expected %0d, got %0d", name, exp_v, got_v);
		end
	endtask

	// command driver: bursts with random gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			cmd <= '0;
			burst_left <= $urandom_range(1, 12);
			gap_left <= 0;
		end else begin
			if (start && !busy)
				carve_expect_q.insert(carve_expect_q.size(), carve_step(cmd));
			if (start && busy) begin
				// hold the transaction until taken
			end else if (gap_left != 0) begin
				start <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (pending_cmds.size() != 0) begin
				start <= 1'b1;
				cmd <= pending_cmds.pop_front();
				if (burst_left <= 1) begin
					burst_left <= ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60)
						: $urandom_range(1, 12);
					gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				start <= 1'b0;
			end
		end
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n && res_valid) begin
			if (carve_expect_q.size() == 0) begin
				fail_count++;
				$error("result transaction with nothing expected");
			end else begin
				want = carve_expect_q.pop_front();
				check_field("edge_valid", 7'(want.edge_valid), 7'(res.edge_valid));
				check_field("from_row", 7'(want.from_row), 7'(res.from_row));
				check_field("from_col", 7'(want.from_col), 7'(res.from_col));
				check_field("to_row", 7'(want.to_row), 7'(res.to_row));
				check_field("to_col", 7'(want.to_col), 7'(res.to_col));
				check_field("direction", 7'(want.direction), 7'(res.direction));
				check_field("done_res", 7'(want.done_res), 7'(res.done_res));
			end
		end
	end

	// watchdog on cycles with no transaction at all
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || res_valid) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("FAIL");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	task automatic wait_drained();
		do
			@(negedge clk);
		while (pending_cmds.size() != 0 || start || carve_expect_q.size() != 0 || busy);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_GRID_SIDE: side_cfg = val;
			REG_START_ROW: row_cfg = val[POS_W-1:0];
			REG_START_COL: col_cfg = val[POS_W-1:0];
			default: ;
		endcase
	endtask

	task automatic queue_item(input logic k, input logic [RAND_W-1:0] rv);
		cmd_t c;
		c.kind = k;
		c.rand_value = rv;
		pending_cmds.insert(pending_cmds.size(), c);
		items_queued++;
	endtask

	// fresh walk opens with a start; a few stray starts break the sequence
	task automatic queue_walk(input int unsigned steps, input bit fresh);
		@(negedge clk);
		if (fresh)
			queue_item(KIND_START, RAND_W'($urandom));
		repeat (steps) begin
			if ($urandom_range(0, 39) == 0)
				queue_item(KIND_START, RAND_W'($urandom));
			else if ($urandom_range(0, 7) == 0)
				queue_item(KIND_STEP, RAND_W'($urandom_range(0, 3)));
			else
				queue_item(KIND_STEP, RAND_W'($urandom));
		end
	endtask

	initial begin
		logic [CFG_W-1:0] pick;
		int unsigned      eff_side, steps;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		wait_drained();

		// step before any start, then a walk on the reset grid
		@(negedge clk);
		queue_item(KIND_STEP, 16'hFFFF);
		queue_item(KIND_START, 16'hFFFF);
		queue_item(KIND_STEP, 16'h0000);
		queue_item(KIND_STEP, 16'h8000);

		// oversize side saturates, far corner start
		wait_drained();
		write_reg(REG_GRID_SIDE, 7'd127);
		write_reg(REG_START_ROW, 7'd63);
		write_reg(REG_START_COL, 7'd63);
		@(negedge clk);
		queue_item(KIND_START, 16'h0000);
		queue_item(KIND_STEP, 16'hFFFF);
		queue_item(KIND_STEP, 16'h0001);
		queue_item(KIND_STEP, 16'h5555);
		queue_item(KIND_STEP, 16'hAAAA);

		// undersize side, start clamped, walk run past completion
		wait_drained();
		write_reg(REG_GRID_SIDE, 7'd0);
		write_reg(REG_START_COL, 7'd0);
		@(negedge clk);
		queue_item(KIND_START, 16'h1234);
		repeat (8)
			queue_item(KIND_STEP, RAND_W'($urandom));

		// grid shrinks in the middle of a walk
		wait_drained();
		write_reg(REG_GRID_SIDE, 7'd5);
		write_reg(REG_START_ROW, 7'd2);
		write_reg(REG_START_COL, 7'd2);
		queue_walk(4, 1'b1);
		wait_drained();
		write_reg(REG_GRID_SIDE, 7'd3);
		queue_walk(4, 1'b0);

		while (items_queued < 720) begin
			wait_drained();
			if ($urandom_range(0, 3) != 0) begin
				pick = CFG_W'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 127)
					: $urandom_range(2, 6));
				write_reg(REG_GRID_SIDE, pick);
			end
			if ($urandom_range(0, 2) != 0) begin
				pick = CFG_W'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 63)
					: $urandom_range(0, 5));
				write_reg(REG_START_ROW, pick);
			end
			if ($urandom_range(0, 2) != 0) begin
				pick = CFG_W'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 63)
					: $urandom_range(0, 5));
				write_reg(REG_START_COL, pick);
			end
			eff_side = (side_cfg < 2) ? 2 : (side_cfg > GRID_MAX) ? GRID_MAX : side_cfg;
			// a full maze takes one push and one pop per cell
			steps = 2 * eff_side * eff_side - 1;
			if (steps > 90)
				steps = $urandom_range(20, 90);
			if ($urandom_range(0, 4) != 0)
				queue_walk(steps + $urandom_range(0, 2), 1'b1);
			else
				queue_walk($urandom_range(3, 15), 1'b0);
		end

		wait_drained();
		repeat (20) @(posedge clk);
		if (carve_expect_q.size() != 0) begin
			fail_count++;
			$error("%0d expected results never arrived", carve_expect_q.size());
		end
		if (fail_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
